// ----- sv/mbh_pkg.sv -----
`default_nettype none
package mbh_pkg;

  localparam int unsigned IDX_W   = 13;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VALUE_W = 32;

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_READ   = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e                 kind;
    logic [TIME_W-1:0]          sample_time;
    logic signed [VALUE_W-1:0]  sample_value;
    logic [IDX_W-1:0]           read_index;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]          entry_time;
    logic signed [VALUE_W-1:0]  entry_value;
    logic [IDX_W-1:0]           stored_count;
    logic                       compacted;
    logic                       restarted;
    logic                       index_bad;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CINIT,
    S_FIRST,
    S_BKT,
    S_SCAN,
    S_EMIT1,
    S_EMIT2,
    S_LAST,
    S_DONE
  } mbh_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_EXEC,
    OP_CINIT,
    OP_FIRST,
    OP_BKT_SKIP,
    OP_BKT_START,
    OP_SCAN,
    OP_EMIT1,
    OP_EMIT2,
    OP_LAST,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    logic compact_need;  // append under way overflows the history
    logic bkt_done;      // all buckets visited
    logic bkt_empty;     // current bucket has no entries
    logic scan_last;     // entry under scan closes the bucket
    logic emit_two;      // bucket keeps two entries
    logic out_busy;      // result register still holds an untaken result
  } dp_status_t;

endpackage
`default_nettype wire

// ----- sv/mbh_in_if.sv -----
`default_nettype none
interface mbh_in_if import mbh_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/mbh_out_if.sv -----
`default_nettype none
interface mbh_out_if import mbh_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/mbh_ctrl.sv -----
`default_nettype none
module mbh_ctrl import mbh_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t st_i,
  output dp_op_e          op_o
);

  mbh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = st_i.compact_need ? S_CINIT : S_DONE;
      end
      S_CINIT: state_d = S_FIRST;
      S_FIRST: state_d = S_BKT;
      S_BKT: begin
        if (st_i.bkt_done) begin
          state_d = S_LAST;
        end else if (!st_i.bkt_empty) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st_i.scan_last) state_d = S_EMIT1;
      end
      S_EMIT1: begin
        state_d = st_i.emit_two ? S_EMIT2 : S_BKT;
      end
      S_EMIT2: state_d = S_BKT;
      S_LAST:  state_d = S_DONE;
      S_DONE: begin
        if (!st_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LATCH;
      end
      S_EXEC:  op_o = OP_EXEC;
      S_CINIT: op_o = OP_CINIT;
      S_FIRST: op_o = OP_FIRST;
      S_BKT: begin
        if (st_i.bkt_done) begin
          op_o = OP_NONE;
        end else if (st_i.bkt_empty) begin
          op_o = OP_BKT_SKIP;
        end else begin
          op_o = OP_BKT_START;
        end
      end
      S_SCAN:  op_o = OP_SCAN;
      S_EMIT1: op_o = OP_EMIT1;
      S_EMIT2: op_o = OP_EMIT2;
      S_LAST:  op_o = OP_LAST;
      S_DONE: begin
        if (!st_i.out_busy) op_o = OP_RESULT;
      end
      default: op_o = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/mbh_datapath.sv -----
`default_nettype none
module mbh_datapath import mbh_pkg::*; #(
  parameter int unsigned MAX_SAMPLES     = 4096,
  parameter int unsigned COMPACT_SAMPLES = 2048,
  parameter int unsigned TIME_BITS       = 32,
  parameter int unsigned VALUE_BITS      = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire dp_op_e    op_i,
  input  wire in_item_t  item_i,
  output dp_status_t     st_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int unsigned DEPTH = MAX_SAMPLES + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMPW  = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned TXW   = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
  localparam int unsigned VXW   = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned BKTS  = (COMPACT_SAMPLES - 2) / 2;
  localparam int unsigned INTER = MAX_SAMPLES - 1;
  localparam int unsigned QI    = INTER / BKTS;
  localparam int unsigned RI    = INTER % BKTS;
  localparam int unsigned BW    = $clog2(BKTS + 1);
  localparam int unsigned RW    = (BKTS > 1) ? $clog2(BKTS) : 1;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [VALUE_BITS-1:0] val_t;

  // history store
  time_t mem_t [DEPTH];
  val_t  mem_v [DEPTH];

  logic          we, re;
  logic [AW-1:0] wa, ra;
  time_t         wt;
  val_t          wv;
  time_t         rd_t_q;
  val_t          rd_v_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_t[wa] <= wt;
      mem_v[wa] <= wv;
    end
    if (re) begin
      rd_t_q <= mem_t[ra];
      rd_v_q <= mem_v[ra];
    end
  end

  in_item_t      item_q, item_d;
  logic [CW-1:0] cnt_q, cnt_d;
  time_t         newest_q, newest_d;
  logic          restart_q, restart_d, compact_q, compact_d, bad_q, bad_d;
  logic [AW-1:0] scan_q, scan_d, end_q, end_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [BW-1:0] bkt_q, bkt_d;
  logic [CW-1:0] kept_q, kept_d;
  time_t         last_kept_q, last_kept_d;
  time_t         lo_t_q, lo_t_d, hi_t_q, hi_t_d;
  val_t          lo_v_q, lo_v_d, hi_v_q, hi_v_d;
  logic          first_q, first_d;
  out_item_t     out_q, out_d;
  logic          out_vld_q, out_vld_d;

  // input fields brought to storage widths
  logic [TXW-1:0] in_t_x;
  logic [VXW-1:0] in_v_x;
  time_t          in_t;
  val_t           in_v;
  assign in_t_x = TXW'(item_q.sample_time);
  assign in_v_x = VXW'(item_q.sample_value);
  assign in_t   = in_t_x[TIME_BITS-1:0];
  assign in_v   = in_v_x[VALUE_BITS-1:0];

  logic            has_any, restart, same;
  logic [CW-1:0]   cnt_new;
  logic [CMPW-1:0] idx_x, cnt_x;
  logic            idx_ok;
  assign has_any = (cnt_q != '0);
  assign restart = has_any && (in_t < newest_q);
  assign same    = has_any && (in_t == newest_q);
  assign cnt_new = same ? cnt_q : (restart ? CW'(1) : cnt_q + CW'(1));
  assign idx_x   = CMPW'(item_q.read_index);
  assign cnt_x   = CMPW'(cnt_q);
  assign idx_ok  = idx_x < cnt_x;

  logic [CW-1:0] cnt_m1;
  assign cnt_m1 = cnt_q - CW'(1);

  // bucket boundary stepping: end(b) = 1 + floor(INTER*(b+1)/BKTS)
  logic [RW:0]   rsum;
  logic          carry;
  logic [RW-1:0] rem_next;
  logic [AW-1:0] end_next;
  assign rsum     = {1'b0, rem_q} + (RW + 1)'(RI);
  assign carry    = rsum >= (RW + 1)'(BKTS);
  assign rem_next = carry ? RW'(rsum - (RW + 1)'(BKTS)) : rsum[RW-1:0];
  assign end_next = end_q + AW'(QI) + AW'(carry);

  logic [AW-1:0] scan_p1;
  assign scan_p1 = scan_q + AW'(1);

  logic  lo_first;
  time_t emit_a_t, emit_b_t;
  val_t  emit_a_v, emit_b_v;
  assign lo_first = lo_t_q <= hi_t_q;
  assign emit_a_t = lo_first ? lo_t_q : hi_t_q;
  assign emit_a_v = lo_first ? lo_v_q : hi_v_q;
  assign emit_b_t = lo_first ? hi_t_q : lo_t_q;
  assign emit_b_v = lo_first ? hi_v_q : lo_v_q;

  logic [TXW-1:0] rd_t_x;
  logic [VXW-1:0] rd_v_x;
  assign rd_t_x = TXW'(rd_t_q);
  assign rd_v_x = VXW'(rd_v_q);

  always_comb begin
    st_o.compact_need = (item_q.kind == KIND_APPEND) && !same
                        && (cnt_new == CW'(DEPTH));
    st_o.bkt_done     = bkt_q == BW'(BKTS);
    st_o.bkt_empty    = scan_q == end_q;
    st_o.scan_last    = scan_p1 == end_q;
    st_o.emit_two     = lo_t_q != hi_t_q;
    st_o.out_busy     = out_vld_q && !out_ready_i;
  end

  always_comb begin
    we          = 1'b0;
    re          = 1'b0;
    wa          = '0;
    ra          = '0;
    wt          = in_t;
    wv          = in_v;
    item_d      = item_q;
    cnt_d       = cnt_q;
    newest_d    = newest_q;
    restart_d   = restart_q;
    compact_d   = compact_q;
    bad_d       = bad_q;
    scan_d      = scan_q;
    end_d       = end_q;
    rem_d       = rem_q;
    bkt_d       = bkt_q;
    kept_d      = kept_q;
    last_kept_d = last_kept_q;
    lo_t_d      = lo_t_q;
    lo_v_d      = lo_v_q;
    hi_t_d      = hi_t_q;
    hi_v_d      = hi_v_q;
    first_d     = first_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    case (op_i)
      OP_LATCH: item_d = item_i;
      OP_EXEC: begin
        if (item_q.kind == KIND_READ) begin
          bad_d     = !idx_ok;
          restart_d = 1'b0;
          compact_d = 1'b0;
          re        = idx_ok;
          ra        = idx_x[AW-1:0];
        end else begin
          bad_d     = 1'b0;
          restart_d = restart;
          compact_d = st_o.compact_need;
          we        = 1'b1;
          wa        = same ? cnt_m1[AW-1:0] : (restart ? '0 : cnt_q[AW-1:0]);
          cnt_d     = cnt_new;
          newest_d  = in_t;
        end
      end
      OP_CINIT: begin
        re     = 1'b1;
        ra     = '0;
        scan_d = AW'(1);
        bkt_d  = '0;
        rem_d  = RW'(RI);
        end_d  = AW'(1 + QI);
        kept_d = CW'(1);
      end
      OP_FIRST: last_kept_d = rd_t_q;
      OP_BKT_SKIP: begin
        bkt_d = bkt_q + BW'(1);
        rem_d = rem_next;
        end_d = end_next;
      end
      OP_BKT_START: begin
        re      = 1'b1;
        ra      = scan_q;
        first_d = 1'b1;
      end
      OP_SCAN: begin
        first_d = 1'b0;
        if (first_q || ($signed(rd_v_q) < $signed(lo_v_q))) begin
          lo_t_d = rd_t_q;
          lo_v_d = rd_v_q;
        end
        if (first_q || ($signed(rd_v_q) > $signed(hi_v_q))) begin
          hi_t_d = rd_t_q;
          hi_v_d = rd_v_q;
        end
        scan_d = scan_p1;
        if (!st_o.scan_last) begin
          re = 1'b1;
          ra = scan_p1;
        end
      end
      OP_EMIT1: begin
        we          = 1'b1;
        wa          = kept_q[AW-1:0];
        wt          = emit_a_t;
        wv          = emit_a_v;
        kept_d      = kept_q + CW'(1);
        last_kept_d = emit_a_t;
        if (!st_o.emit_two) begin
          bkt_d = bkt_q + BW'(1);
          rem_d = rem_next;
          end_d = end_next;
        end
      end
      OP_EMIT2: begin
        we          = 1'b1;
        wa          = kept_q[AW-1:0];
        wt          = emit_b_t;
        wv          = emit_b_v;
        kept_d      = kept_q + CW'(1);
        last_kept_d = emit_b_t;
        bkt_d       = bkt_q + BW'(1);
        rem_d       = rem_next;
        end_d       = end_next;
      end
      OP_LAST: begin
        // newest sample is the item just appended
        newest_d = in_t;
        if (last_kept_q != in_t) begin
          we    = 1'b1;
          wa    = kept_q[AW-1:0];
          cnt_d = kept_q + CW'(1);
        end else begin
          cnt_d = kept_q;
        end
      end
      OP_RESULT: begin
        out_vld_d = 1'b1;
        if (item_q.kind == KIND_READ) begin
          out_d.entry_time  = bad_q ? '0 : rd_t_x[TIME_W-1:0];
          out_d.entry_value = bad_q ? '0 : rd_v_x[VALUE_W-1:0];
          out_d.compacted   = 1'b0;
          out_d.restarted   = 1'b0;
          out_d.index_bad   = bad_q;
        end else begin
          out_d.entry_time  = '0;
          out_d.entry_value = '0;
          out_d.compacted   = compact_q;
          out_d.restarted   = restart_q;
          out_d.index_bad   = 1'b0;
        end
        out_d.stored_count = cnt_x[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    newest_q    <= newest_d;
    restart_q   <= restart_d;
    compact_q   <= compact_d;
    bad_q       <= bad_d;
    scan_q      <= scan_d;
    end_q       <= end_d;
    rem_q       <= rem_d;
    bkt_q       <= bkt_d;
    kept_q      <= kept_d;
    last_kept_q <= last_kept_d;
    lo_t_q      <= lo_t_d;
    lo_v_q      <= lo_v_d;
    hi_t_q      <= hi_t_d;
    hi_v_q      <= hi_v_d;
    first_q     <= first_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- sv/minmax_bucket_history_compactor.sv -----
// Channel  Dir  Handshake       Payload
// in_i     in   valid/ready     kind, sample_time, sample_value, read_index
// out_o    out  valid/ready     entry_time, entry_value, stored_count, compacted,
//                               restarted, index_bad
//
// Append or read: the result is registered after the execute and load steps; the
//   next transfer waits for the load step, so each item is done before the next.
// Compacting append: adds the init, first and last steps and a walk of the store; the
//   walk reads one entry per cycle and spends a start step and up to two write steps
//   on each bucket that holds entries.
// Reset clears the sample count and the result valid; the store needs no clearing.
// A new item is taken while a result waits on out_o; a stalled result holds the
//   next one in the load step until out_o drains.
`default_nettype none
module minmax_bucket_history_compactor import mbh_pkg::*; #(
  parameter int unsigned MAX_SAMPLES     = 4096,
  parameter int unsigned COMPACT_SAMPLES = 2048,
  parameter int unsigned TIME_BITS       = 32,
  parameter int unsigned VALUE_BITS      = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mbh_in_if.sink    in_i,
  mbh_out_if.source out_o
);

  dp_op_e     op;
  dp_status_t st;
  logic       in_ready;

  mbh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .op_o       (op)
  );

  mbh_datapath #(
    .MAX_SAMPLES     (MAX_SAMPLES),
    .COMPACT_SAMPLES (COMPACT_SAMPLES),
    .TIME_BITS       (TIME_BITS),
    .VALUE_BITS      (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .item_i      (in_i.data),
    .st_o        (st),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

  // an input transfer is always followed by its execute step
  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> op == OP_EXEC)
    else $error("execute step missing after input transfer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> 32'(out_o.data.stored_count) <= MAX_SAMPLES)
    else $error("stored count above limit");

  a_compact_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.compacted
      |-> 32'(out_o.data.stored_count) <= COMPACT_SAMPLES && !out_o.data.restarted)
    else $error("compaction left too many samples");

  // no item is taken while a compaction walks the store
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op == OP_SCAN || op == OP_EMIT1 || op == OP_EMIT2 |-> !in_i.ready)
    else $error("input ready during compaction");

endmodule
`default_nettype wire
